### rtl/csb_pkg.sv
package csb_pkg;

  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SPACE  = 8'h20;

  typedef enum logic [3:0] {
    MODE_CODE  = 4'b0001,
    MODE_LINE  = 4'b0010,
    MODE_BLOCK = 4'b0100,
    MODE_STR   = 4'b1000
  } mode_t;

endpackage

### rtl/comment_and_string_blanker_top.sv
// Comment and string blanker.
// Slave stream s_*: one source byte per transaction, tlast marks the final
// byte of a text. Master stream m_*: the blanked text, one byte per
// transaction, in the same positions; tlast marks the final byte of a text.
// Comments and quoted literals become spaces; newlines inside them are kept
// unless escaped in a literal. A byte's result appears on m_* in the cycle
// after the byte is taken. A slash in code is held until the next byte
// decides whether a comment opens, so such a byte gives no result of its
// own and the next byte gives two transactions.
// Throughput: one byte per cycle while m_tready is high; after a byte that
// gives two results, s_tready stays low until the single-byte master port
// has drained one entry of the two-entry result register.
// Reset: scanner returns to code mode and the result register empties.
// A held slash and an open comment or literal end with the tlast byte.
// Stall: while m_tready is low the result register holds its contents;
// s_tready drops as soon as a new byte could not be stored.
module comment_and_string_blanker_top
  import csb_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] text_byte
  input  logic       s_tlast,   // text_end
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] clean_byte
  output logic       m_tlast    // clean_end
);

  mode_t      mode, mode_next;
  logic       quote_single, quote_single_next;
  logic       star_seen, star_seen_next;
  logic       esc_pending, esc_pending_next;
  logic       slash_held, slash_held_next;

  logic [7:0] ob0, ob1;
  logic       oe0, oe1;
  logic [1:0] ocnt;

  logic [7:0] b0, b1;
  logic [1:0] n;
  logic       e0, e1;
  logic [7:0] c;
  logic [7:0] blank_nl;
  logic [7:0] q;
  logic       accept, pop;

  assign c        = s_tdata;
  assign blank_nl = (c == CH_NL) ? CH_NL : CH_SPACE;
  assign q        = quote_single ? CH_SQUOTE : CH_DQUOTE;

  assign s_tready = (ocnt == 2'd0) || ((ocnt == 2'd1) && m_tready);
  assign accept   = s_tvalid && s_tready;
  assign m_tvalid = (ocnt != 2'd0);
  assign pop      = m_tvalid && m_tready;
  assign m_tdata  = ob0;
  assign m_tlast  = oe0;

  always_comb begin
    mode_next         = mode;
    quote_single_next = quote_single;
    star_seen_next    = star_seen;
    esc_pending_next  = esc_pending;
    slash_held_next   = slash_held;
    b0 = CH_SPACE;
    b1 = CH_SPACE;
    n  = 2'd1;
    e0 = 1'b0;
    e1 = 1'b0;
    unique case (mode)
      MODE_CODE: begin
        if (slash_held && (c == CH_SLASH)) begin
          slash_held_next = 1'b0;
          mode_next       = MODE_LINE;
          n               = 2'd2;
        end else if (slash_held && (c == CH_STAR)) begin
          slash_held_next = 1'b0;
          mode_next       = MODE_BLOCK;
          star_seen_next  = 1'b0;
          n               = 2'd2;
        end else if (slash_held) begin
          slash_held_next = 1'b0;
          b0              = CH_SLASH;
          n               = 2'd2;
          if ((c == CH_DQUOTE) || (c == CH_SQUOTE)) begin
            mode_next         = MODE_STR;
            quote_single_next = (c == CH_SQUOTE);
            esc_pending_next  = 1'b0;
            b1                = CH_SPACE;
          end else begin
            b1 = c;
          end
        end else if (c == CH_SLASH) begin
          slash_held_next = 1'b1;
          n               = 2'd0;
        end else if ((c == CH_DQUOTE) || (c == CH_SQUOTE)) begin
          mode_next         = MODE_STR;
          quote_single_next = (c == CH_SQUOTE);
          esc_pending_next  = 1'b0;
        end else begin
          b0 = c;
        end
      end
      MODE_LINE: begin
        if (c == CH_NL) begin
          mode_next = MODE_CODE;
          b0        = CH_NL;
        end
      end
      MODE_BLOCK: begin
        if (star_seen && (c == CH_SLASH)) begin
          mode_next      = MODE_CODE;
          star_seen_next = 1'b0;
        end else begin
          star_seen_next = (c == CH_STAR);
          b0             = blank_nl;
        end
      end
      MODE_STR: begin
        if (esc_pending) begin
          esc_pending_next = 1'b0;
        end else if (c == CH_BSLASH) begin
          esc_pending_next = 1'b1;
        end else if (c == q) begin
          mode_next = MODE_CODE;
        end else begin
          b0 = blank_nl;
        end
      end
      default: begin
        mode_next = MODE_CODE;
      end
    endcase

    if (s_tlast) begin
      // flush held slash; the only such case leaves no other result
      if (slash_held_next) begin
        b0 = CH_SLASH;
        n  = 2'd1;
      end
      if (n == 2'd2) begin
        e1 = 1'b1;
      end else begin
        e0 = 1'b1;
      end
      mode_next         = MODE_CODE;
      quote_single_next = 1'b0;
      star_seen_next    = 1'b0;
      esc_pending_next  = 1'b0;
      slash_held_next   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= MODE_CODE;
      quote_single <= 1'b0;
      star_seen    <= 1'b0;
      esc_pending  <= 1'b0;
      slash_held   <= 1'b0;
      ocnt         <= 2'd0;
    end else begin
      if (accept) begin
        mode         <= mode_next;
        quote_single <= quote_single_next;
        star_seen    <= star_seen_next;
        esc_pending  <= esc_pending_next;
        slash_held   <= slash_held_next;
        ocnt         <= n;
      end else if (pop) begin
        ocnt <= ocnt - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ob0 <= b0;
      oe0 <= e0;
      ob1 <= b1;
      oe1 <= e1;
    end else if (pop) begin
      ob0 <= ob1;
      oe0 <= oe1;
    end
  end

endmodule

### rtl/csb_checker.sv
module csb_checker
  import csb_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       s_tvalid,
  input logic       s_tready,
  input logic       s_tlast,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata,
  input logic       m_tlast
);

  a_valid_holds: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> m_tvalid)
    else $error("m_tvalid dropped while stalled");

  a_data_holds: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> ($stable(m_tdata) && $stable(m_tlast)))
    else $error("m_tdata changed while stalled");

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |-> !s_tready)
    else $error("input taken while result stalled");

  a_end_gives_result: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && s_tlast) |=> m_tvalid)
    else $error("final byte produced no result");

endmodule

bind comment_and_string_blanker_top csb_checker u_csb_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tlast  (s_tlast),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);
